[rtl/sorted_table_search_engine_defines.svh]
// ----------------------------------------------------------------------------
// Sorted table search engine: assertion macros
// Shared property wrappers, clocked on clk and quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_SEARCH_ENGINE_DEFINES_SVH
`define SORTED_TABLE_SEARCH_ENGINE_DEFINES_SVH

// Same-cycle implication
`define STE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define STE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ste_pkg.sv]
// ----------------------------------------------------------------------------
// ste_pkg
// Widths, defaults, command codes and state codes of the search engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ste_pkg;

	// Fixed field widths
	localparam int unsigned LEN_W = 11;
	localparam int unsigned IDX_W = 10;
	localparam int unsigned ACT_W = 2;

	// Parameter defaults
	localparam int unsigned DEF_TABLE_DEPTH = 1024;
	localparam int unsigned DEF_VALUE_W     = 32;

	// Command codes
	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD  = 2'd0,
		ACT_EXACT = 2'd1,
		ACT_LOWER = 2'd2,
		ACT_UPPER = 2'd3
	} action_t;

	// Search sequencer states
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PROBE = 3'b010,
		ST_CMP   = 3'b100
	} state_t;

endpackage

[rtl/ste_table_ram.sv]
// ----------------------------------------------------------------------------
// ste_table_ram
// Single-clock table store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ste_table_ram #(
	parameter int unsigned DEPTH   = ste_pkg::DEF_TABLE_DEPTH,
	parameter int unsigned VALUE_W = ste_pkg::DEF_VALUE_W
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [VALUE_W-1:0]       wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [VALUE_W-1:0]       rd_data_q
);

	logic [VALUE_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

[rtl/sorted_table_search_engine.sv]
// ----------------------------------------------------------------------------
// sorted_table_search_engine
// Binary search (exact, lower bound, upper bound) over a table of signed
// entries held in a synchronous RAM.
//
//   channel   handshake            payload
//   -------   ------------------   ---------------------------------------
//   command   start / busy         action, entry_index, data_value
//   result    done (strobe)        found, position
//   config    cfg_valid/cfg_ready  table_length
//
// A load raises no busy. A query holds busy while it runs its probes,
// P being the number of probes (at most ceil(log2(L+1)), 11 for a
// 1024-entry table); an exact search ends early when it hits. Each probe
// is one RAM read plus one compare.
// done pulses for one cycle as busy falls; a new command may be taken
// in that same cycle. Reset clears the sequencer and table_length; the
// table contents are undefined until loaded. The result side never stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_table_search_engine_defines.svh"

module sorted_table_search_engine #(
	parameter int unsigned TABLE_DEPTH = ste_pkg::DEF_TABLE_DEPTH,
	parameter int unsigned VALUE_WIDTH = ste_pkg::DEF_VALUE_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command
	input  logic                        start,
	output logic                        busy,
	input  logic [ste_pkg::ACT_W-1:0]   action,
	input  logic [ste_pkg::IDX_W-1:0]   entry_index,
	input  logic signed [VALUE_WIDTH-1:0] data_value,
	// result
	output logic                        done,
	output logic                        found,
	output logic [ste_pkg::LEN_W-1:0]   position,
	// config
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ste_pkg::LEN_W-1:0]   table_length
);

	localparam int unsigned LW      = ste_pkg::LEN_W;
	localparam int unsigned AW      = $clog2(TABLE_DEPTH);
	localparam int unsigned LEN_CAP = (TABLE_DEPTH < 2047) ? TABLE_DEPTH : 2047;

	ste_pkg::state_t         state_q;
	ste_pkg::action_t        mode_q;
	logic [LW-1:0]           table_length_q;
	logic [LW-1:0]           len_eff;
	logic [LW-1:0]           len_s1;
	logic [LW-1:0]           lo_q;
	logic [LW-1:0]           hi_q;
	logic [LW-1:0]           ans_q;
	logic [LW-1:0]           mid;
	logic [LW-1:0]           mid_q;
	logic signed [VALUE_WIDTH-1:0] key_q;
	logic [VALUE_WIDTH-1:0]  rd_data;
	logic signed [VALUE_WIDTH-1:0] entry;
	logic                    accept;
	logic                    is_load;
	logic                    wr_en;
	logic                    rd_en;
	logic                    ent_eq;
	logic                    ent_gt;
	logic                    go_left;
	logic                    done_q;
	logic                    found_q;
	logic [LW-1:0]           position_q;

	// Config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			table_length_q <= table_length;
		end
	end

	// Length saturated to the table depth
	assign len_eff = (table_length_q > LW'(LEN_CAP)) ? LW'(LEN_CAP) : table_length_q;

	// Command decode
	assign busy    = (state_q != ste_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign is_load = (action == ste_pkg::ACT_LOAD);
	assign wr_en   = accept && is_load && (int'(entry_index) < TABLE_DEPTH);

	// Floor midpoint of the closed range lo .. hi-1
	assign mid   = lo_q + ((hi_q - LW'(1) - lo_q) >> 1);
	assign rd_en = (state_q == ste_pkg::ST_PROBE) && (lo_q < hi_q);

	ste_table_ram #(
		.DEPTH   (TABLE_DEPTH),
		.VALUE_W (VALUE_WIDTH)
	) u_table (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (AW'(entry_index)),
		.wr_data   (data_value),
		.rd_en     (rd_en),
		.rd_addr   (AW'(mid)),
		.rd_data_q (rd_data)
	);

	// Probe compare
	assign entry  = $signed(rd_data);
	assign ent_eq = (entry == key_q);
	assign ent_gt = (entry > key_q);

	always_comb begin
		case (mode_q)
			ste_pkg::ACT_LOWER: go_left = ent_gt || ent_eq;
			default:            go_left = ent_gt;
		endcase
	end

	// Search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ste_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ste_pkg::ST_IDLE: begin
					if (accept && !is_load) begin
						state_q <= ste_pkg::ST_PROBE;
					end
				end
				ste_pkg::ST_PROBE: begin
					if (lo_q < hi_q) begin
						state_q <= ste_pkg::ST_CMP;
					end else begin
						state_q <= ste_pkg::ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ste_pkg::ST_CMP: begin
					if (mode_q == ste_pkg::ACT_EXACT && ent_eq) begin
						state_q <= ste_pkg::ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ste_pkg::ST_PROBE;
					end
				end
				default: begin
					state_q <= ste_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Search range, key and result words
	always_ff @(posedge clk) begin
		case (state_q)
			ste_pkg::ST_IDLE: begin
				if (accept && !is_load) begin
					mode_q <= ste_pkg::action_t'(action);
					key_q  <= data_value;
					len_s1 <= len_eff;
					lo_q   <= '0;
					hi_q   <= len_eff;
					ans_q  <= len_eff;
				end
			end
			ste_pkg::ST_PROBE: begin
				mid_q <= mid;
				if (!(lo_q < hi_q)) begin
					position_q <= ans_q;
					found_q    <= (mode_q != ste_pkg::ACT_EXACT) && (ans_q < len_s1);
				end
			end
			ste_pkg::ST_CMP: begin
				if (mode_q == ste_pkg::ACT_EXACT) begin
					if (ent_eq) begin
						position_q <= mid_q;
						found_q    <= 1'b1;
					end else if (ent_gt) begin
						hi_q <= mid_q;
					end else begin
						lo_q <= mid_q + LW'(1);
					end
				end else if (go_left) begin
					ans_q <= mid_q;
					hi_q  <= mid_q;
				end else begin
					lo_q <= mid_q + LW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign done     = done_q;
	assign found    = found_q;
	assign position = position_q;

	// Checks
	`STE_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while a search is running")
	`STE_ASSERT_NOW(a_probe_range, state_q == ste_pkg::ST_CMP, lo_q < hi_q,
		"compare step with an empty search range")
	`STE_ASSERT_NOW(a_pos_bound, done, position <= len_s1, "position beyond table length")
	`STE_ASSERT_NEXT(a_query_busy, accept && !is_load, busy, "query taken but not busy")

endmodule
